// File: rtl/caf6502_pkg.sv
// Shared types and codes for the 6502 ALU and status-flag core.
package caf6502_pkg;

    localparam logic [5:0] CMD_LDA = 6'd0;
    localparam logic [5:0] CMD_LDX = 6'd1;
    localparam logic [5:0] CMD_LDY = 6'd2;
    localparam logic [5:0] CMD_STA = 6'd3;
    localparam logic [5:0] CMD_STX = 6'd4;
    localparam logic [5:0] CMD_STY = 6'd5;
    localparam logic [5:0] CMD_ADC = 6'd6;
    localparam logic [5:0] CMD_SBC = 6'd7;
    localparam logic [5:0] CMD_CMP = 6'd8;
    localparam logic [5:0] CMD_CPX = 6'd9;
    localparam logic [5:0] CMD_CPY = 6'd10;
    localparam logic [5:0] CMD_AND = 6'd11;
    localparam logic [5:0] CMD_ORA = 6'd12;
    localparam logic [5:0] CMD_EOR = 6'd13;
    localparam logic [5:0] CMD_BIT = 6'd14;
    localparam logic [5:0] CMD_ASL = 6'd15;
    localparam logic [5:0] CMD_LSR = 6'd16;
    localparam logic [5:0] CMD_ROL = 6'd17;
    localparam logic [5:0] CMD_ROR = 6'd18;
    localparam logic [5:0] CMD_INC = 6'd19;
    localparam logic [5:0] CMD_DEC = 6'd20;
    localparam logic [5:0] CMD_CLC = 6'd21;
    localparam logic [5:0] CMD_SEC = 6'd22;
    localparam logic [5:0] CMD_CLD = 6'd23;
    localparam logic [5:0] CMD_SED = 6'd24;
    localparam logic [5:0] CMD_CLI = 6'd25;
    localparam logic [5:0] CMD_SEI = 6'd26;
    localparam logic [5:0] CMD_CLV = 6'd27;
    localparam logic [5:0] CMD_BPL = 6'd28;
    localparam logic [5:0] CMD_BMI = 6'd29;
    localparam logic [5:0] CMD_BVC = 6'd30;
    localparam logic [5:0] CMD_BVS = 6'd31;
    localparam logic [5:0] CMD_BCC = 6'd32;
    localparam logic [5:0] CMD_BCS = 6'd33;
    localparam logic [5:0] CMD_BNE = 6'd34;
    localparam logic [5:0] CMD_BEQ = 6'd35;

    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_D = 3;
    localparam int FLAG_B = 4;
    localparam int FLAG_ONE = 5;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    localparam logic [7:0] STATUS_RESET = 8'h24;

    typedef struct packed {
        logic [5:0] command;
        logic [7:0] operand;
        logic       on_accumulator;
    } cmd_t;

    typedef struct packed {
        logic [7:0] store_value;
        logic       store_valid;
        logic       branch_taken;
        logic [7:0] acc_out;
        logic [7:0] x_out;
        logic [7:0] y_out;
        logic [7:0] status_out;
    } res_t;

endpackage

// File: rtl/cpu_alu_flags_6502_core.sv
// Top level: 6502 ALU, register file and status flags with registered input and result.
// Flow: an accepted item waits in the input register and is executed into the result register once that is free.
// Throughput: one item per cycle; input stalls only while res_stall holds a full result.
// Reset: asynchronous, active low; A, X, Y clear to zero, P to 0x24, both stages empty.
module cpu_alu_flags_6502_core
    import caf6502_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    logic       in_valid_reg;
    logic       in_valid_next;
    cmd_t       in_item_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    res_t       out_item_reg;
    res_t       out_item_next;

    logic [7:0] a_reg, a_next;
    logic [7:0] x_reg, x_next;
    logic [7:0] y_reg, y_next;
    logic [7:0] p_reg, p_next;

    logic       out_free;
    logic       exec;
    logic       accept;

    logic [7:0] m;
    logic       c_in;
    logic [8:0] sum9;
    logic [7:0] addend;
    logic [7:0] cmp_src;
    logic [8:0] diff9;
    logic [7:0] sh_src;
    logic [7:0] sh_res;
    logic [7:0] zn_val;
    logic       zn_en;
    logic [7:0] store_val;
    logic       store_en;
    logic       branch;

    assign out_free  = !out_valid_reg || !res_stall;
    assign exec      = in_valid_reg && out_free;
    assign cmd_stall = in_valid_reg && !out_free;
    assign accept    = cmd_valid && !cmd_stall;

    assign m       = in_item_reg.operand;
    assign c_in    = p_reg[FLAG_C];
    assign addend  = (in_item_reg.command == CMD_SBC) ? ~m : m;
    assign sum9    = {1'b0, a_reg} + {1'b0, addend} + {8'd0, c_in};
    assign cmp_src = (in_item_reg.command == CMD_CPX) ? x_reg :
                     (in_item_reg.command == CMD_CPY) ? y_reg : a_reg;
    assign diff9   = {1'b0, cmp_src} - {1'b0, m};
    assign sh_src  = in_item_reg.on_accumulator ? a_reg : m;

    always_comb
    begin
        sh_res = 8'd0;
        case (in_item_reg.command)
            CMD_ASL: sh_res = {sh_src[6:0], 1'b0};
            CMD_ROL: sh_res = {sh_src[6:0], c_in};
            CMD_LSR: sh_res = {1'b0, sh_src[7:1]};
            CMD_ROR: sh_res = {c_in, sh_src[7:1]};
            default: sh_res = 8'd0;
        endcase
    end

    always_comb
    begin
        a_next    = a_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        p_next    = p_reg;
        zn_val    = 8'd0;
        zn_en     = 1'b0;
        store_val = 8'd0;
        store_en  = 1'b0;
        branch    = 1'b0;
        unique case (in_item_reg.command) inside
            CMD_LDA:
            begin
                a_next = m;
                zn_val = m;
                zn_en  = 1'b1;
            end
            CMD_LDX:
            begin
                x_next = m;
                zn_val = m;
                zn_en  = 1'b1;
            end
            CMD_LDY:
            begin
                y_next = m;
                zn_val = m;
                zn_en  = 1'b1;
            end
            CMD_STA:
            begin
                store_val = a_reg;
                store_en  = 1'b1;
            end
            CMD_STX:
            begin
                store_val = x_reg;
                store_en  = 1'b1;
            end
            CMD_STY:
            begin
                store_val = y_reg;
                store_en  = 1'b1;
            end
            CMD_ADC, CMD_SBC:
            begin
                a_next         = sum9[7:0];
                p_next[FLAG_C] = sum9[8];
                p_next[FLAG_V] = ~(a_reg[7] ^ addend[7]) & (a_reg[7] ^ sum9[7]);
                zn_val         = sum9[7:0];
                zn_en          = 1'b1;
            end
            CMD_CMP, CMD_CPX, CMD_CPY:
            begin
                p_next[FLAG_C] = !diff9[8];
                zn_val         = diff9[7:0];
                zn_en          = 1'b1;
            end
            CMD_AND:
            begin
                a_next = a_reg & m;
                zn_val = a_reg & m;
                zn_en  = 1'b1;
            end
            CMD_ORA:
            begin
                a_next = a_reg | m;
                zn_val = a_reg | m;
                zn_en  = 1'b1;
            end
            CMD_EOR:
            begin
                a_next = a_reg ^ m;
                zn_val = a_reg ^ m;
                zn_en  = 1'b1;
            end
            CMD_BIT:
            begin
                p_next[FLAG_Z] = ((a_reg & m) == 8'd0);
                p_next[FLAG_N] = m[7];
                p_next[FLAG_V] = m[6];
            end
            CMD_ASL, CMD_LSR, CMD_ROL, CMD_ROR:
            begin
                p_next[FLAG_C] = ((in_item_reg.command == CMD_ASL) ||
                                  (in_item_reg.command == CMD_ROL)) ? sh_src[7] : sh_src[0];
                zn_val = sh_res;
                zn_en  = 1'b1;
                if (in_item_reg.on_accumulator)
                begin
                    a_next = sh_res;
                end
                else
                begin
                    store_val = sh_res;
                    store_en  = 1'b1;
                end
            end
            CMD_INC:
            begin
                store_val = m + 8'd1;
                store_en  = 1'b1;
                zn_val    = m + 8'd1;
                zn_en     = 1'b1;
            end
            CMD_DEC:
            begin
                store_val = m - 8'd1;
                store_en  = 1'b1;
                zn_val    = m - 8'd1;
                zn_en     = 1'b1;
            end
            CMD_CLC: p_next[FLAG_C] = 1'b0;
            CMD_SEC: p_next[FLAG_C] = 1'b1;
            CMD_CLD: p_next[FLAG_D] = 1'b0;
            CMD_SED: p_next[FLAG_D] = 1'b1;
            CMD_CLI: p_next[FLAG_I] = 1'b0;
            CMD_SEI: p_next[FLAG_I] = 1'b1;
            CMD_CLV: p_next[FLAG_V] = 1'b0;
            CMD_BPL: branch = !p_reg[FLAG_N];
            CMD_BMI: branch = p_reg[FLAG_N];
            CMD_BVC: branch = !p_reg[FLAG_V];
            CMD_BVS: branch = p_reg[FLAG_V];
            CMD_BCC: branch = !p_reg[FLAG_C];
            CMD_BCS: branch = p_reg[FLAG_C];
            CMD_BNE: branch = !p_reg[FLAG_Z];
            CMD_BEQ: branch = p_reg[FLAG_Z];
            default: branch = 1'b0;
        endcase
        if (zn_en)
        begin
            p_next[FLAG_Z] = (zn_val == 8'd0);
            p_next[FLAG_N] = zn_val[7];
        end
    end

    always_comb
    begin
        out_item_next.store_value  = store_val;
        out_item_next.store_valid  = store_en;
        out_item_next.branch_taken = branch;
        out_item_next.acc_out      = a_next;
        out_item_next.x_out        = x_next;
        out_item_next.y_out        = y_next;
        out_item_next.status_out   = p_next;
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (exec)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            a_reg         <= 8'd0;
            x_reg         <= 8'd0;
            y_reg         <= 8'd0;
            p_reg         <= STATUS_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (exec)
            begin
                a_reg <= a_next;
                x_reg <= x_next;
                y_reg <= y_next;
                p_reg <= p_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= cmd;
        end
        if (exec)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_item_reg;

endmodule

// File: rtl/caf6502_chk.sv
// Port-level checker for the 6502 ALU core and its bind to the top level.
module caf6502_chk
    import caf6502_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic res_valid,
    input logic res_stall,
    input res_t res
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result item changed while stalled");

    a_store_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.store_valid |-> res.store_value == 8'd0)
        else $error("store value set without store");

    a_fixed_bits: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.status_out[FLAG_ONE] && !res.status_out[FLAG_B])
        else $error("status bits 4 and 5 changed");

    a_store_branch: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res.store_valid && res.branch_taken))
        else $error("store and branch in one item");

endmodule

bind cpu_alu_flags_6502_core caf6502_chk u_caf6502_chk (.*);

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the 6502 ALU and status-flag core.
module tb
    import caf6502_pkg::*;
();

    localparam logic [5:0] CMD_NONE_LOW = 6'd36;
    localparam logic [5:0] CMD_NONE_HIGH = 6'd63;
    localparam int N_DIRECTED = 45;
    localparam int RANDOM_ITEMS = 1800;
    localparam int QUIET_ITEMS = 200;
    localparam int PRESSURE_AT = 300;
    localparam int PRESSURE_CYCLES = 80;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        cmd_t item;
        logic typed;
        res_t want;
    } row_t;

    row_t directed_rows [N_DIRECTED] = '{
        '{'{CMD_BPL, 8'h00, 1'b0}, 1'b1, '{8'h00, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00, 8'h24}},
        '{'{CMD_LDA, 8'h80, 1'b0}, 1'b1, '{8'h00, 1'b0, 1'b0, 8'h80, 8'h00, 8'h00, 8'hA4}},
        '{'{CMD_LDA, 8'h00, 1'b1}, 1'b1, '{8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h26}},
        '{'{CMD_LDX, 8'hFF, 1'b0}, 1'b1, '{8'h00, 1'b0, 1'b0, 8'h00, 8'hFF, 8'h00, 8'hA4}},
        '{'{CMD_LDY, 8'h7F, 1'b0}, 1'b1, '{8'h00, 1'b0, 1'b0, 8'h00, 8'hFF, 8'h7F, 8'h24}},
        '{'{CMD_STA, 8'h55, 1'b0}, 1'b1, '{8'h00, 1'b1, 1'b0, 8'h00, 8'hFF, 8'h7F, 8'h24}},
        '{'{CMD_STX, 8'h00, 1'b0}, 1'b1, '{8'hFF, 1'b1, 1'b0, 8'h00, 8'hFF, 8'h7F, 8'h24}},
        '{'{CMD_STY, 8'h00, 1'b1}, 1'b1, '{8'h7F, 1'b1, 1'b0, 8'h00, 8'hFF, 8'h7F, 8'h24}},
        '{'{CMD_SEC, 8'h00, 1'b0}, 1'b1, '{8'h00, 1'b0, 1'b0, 8'h00, 8'hFF, 8'h7F, 8'h25}},
        '{'{CMD_SED, 8'h00, 1'b0}, 1'b1, '{8'h00, 1'b0, 1'b0, 8'h00, 8'hFF, 8'h7F, 8'h2D}},
        '{'{CMD_CLI, 8'h00, 1'b0}, 1'b1, '{8'h00, 1'b0, 1'b0, 8'h00, 8'hFF, 8'h7F, 8'h29}},
        '{'{CMD_SEI, 8'h00, 1'b0}, 1'b1, '{8'h00, 1'b0, 1'b0, 8'h00, 8'hFF, 8'h7F, 8'h2D}},
        '{'{CMD_NONE_HIGH, 8'hFF, 1'b1}, 1'b1,
          '{8'h00, 1'b0, 1'b0, 8'h00, 8'hFF, 8'h7F, 8'h2D}},
        '{'{CMD_ADC, 8'hFF, 1'b0}, 1'b0, '0},
        '{'{CMD_LDA, 8'h7F, 1'b0}, 1'b0, '0},
        '{'{CMD_ADC, 8'h01, 1'b0}, 1'b0, '0},
        '{'{CMD_SBC, 8'h00, 1'b0}, 1'b0, '0},
        '{'{CMD_SBC, 8'hFF, 1'b0}, 1'b0, '0},
        '{'{CMD_LDA, 8'h80, 1'b0}, 1'b0, '0},
        '{'{CMD_SBC, 8'h01, 1'b0}, 1'b0, '0},
        '{'{CMD_CMP, 8'h7F, 1'b0}, 1'b0, '0},
        '{'{CMD_CPX, 8'hFF, 1'b0}, 1'b0, '0},
        '{'{CMD_CPY, 8'h80, 1'b0}, 1'b0, '0},
        '{'{CMD_AND, 8'h0F, 1'b0}, 1'b0, '0},
        '{'{CMD_ORA, 8'hF0, 1'b0}, 1'b0, '0},
        '{'{CMD_EOR, 8'hFF, 1'b0}, 1'b0, '0},
        '{'{CMD_BIT, 8'hC0, 1'b0}, 1'b0, '0},
        '{'{CMD_BIT, 8'h00, 1'b0}, 1'b0, '0},
        '{'{CMD_ASL, 8'h00, 1'b1}, 1'b0, '0},
        '{'{CMD_LSR, 8'h01, 1'b0}, 1'b0, '0},
        '{'{CMD_ROL, 8'h00, 1'b1}, 1'b0, '0},
        '{'{CMD_ROR, 8'h80, 1'b0}, 1'b0, '0},
        '{'{CMD_INC, 8'hFF, 1'b1}, 1'b0, '0},
        '{'{CMD_DEC, 8'h00, 1'b0}, 1'b0, '0},
        '{'{CMD_CLC, 8'h00, 1'b0}, 1'b0, '0},
        '{'{CMD_CLD, 8'h00, 1'b0}, 1'b0, '0},
        '{'{CMD_CLV, 8'h00, 1'b0}, 1'b0, '0},
        '{'{CMD_BMI, 8'h00, 1'b0}, 1'b0, '0},
        '{'{CMD_BVC, 8'h00, 1'b0}, 1'b0, '0},
        '{'{CMD_BVS, 8'h00, 1'b0}, 1'b0, '0},
        '{'{CMD_BCC, 8'h00, 1'b0}, 1'b0, '0},
        '{'{CMD_BCS, 8'h00, 1'b0}, 1'b0, '0},
        '{'{CMD_BNE, 8'h00, 1'b0}, 1'b0, '0},
        '{'{CMD_BEQ, 8'h00, 1'b0}, 1'b0, '0},
        '{'{CMD_NONE_LOW, 8'hAA, 1'b0}, 1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_t res;

    logic row_typed = 1'b0;
    res_t row_want = '0;

    logic [7:0] cpu_a = 8'h00;
    logic [7:0] cpu_x = 8'h00;
    logic [7:0] cpu_y = 8'h00;
    logic [7:0] cpu_p = STATUS_RESET;

    res_t expected_results [$];
    res_t predicted;
    res_t oldest;
    int error_count = 0;
    int items_taken = 0;
    int cycle_count = 0;
    bit quiet_tail = 1'b0;
    bit stimulus_done = 1'b0;

    cpu_alu_flags_6502_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always #10 clk = ~clk;

    function automatic void set_zn(logic [7:0] value);
        cpu_p[FLAG_Z] = (value == 8'h00);
        cpu_p[FLAG_N] = value[7];
    endfunction

    function automatic void compare_with(logic [7:0] reg_value, logic [7:0] m);
        logic [7:0] diff;
        diff = reg_value - m;
        cpu_p[FLAG_C] = (reg_value >= m);
        set_zn(diff);
    endfunction

    function automatic res_t execute_instruction(cmd_t c);
        res_t r;
        logic [8:0] sum;
        logic [7:0] value;
        logic [7:0] shift_src;
        logic carry_in;
        r = '0;
        carry_in = cpu_p[FLAG_C];
        case (c.command)
            CMD_LDA: begin cpu_a = c.operand; set_zn(cpu_a); end
            CMD_LDX: begin cpu_x = c.operand; set_zn(cpu_x); end
            CMD_LDY: begin cpu_y = c.operand; set_zn(cpu_y); end
            CMD_STA: begin r.store_value = cpu_a; r.store_valid = 1'b1; end
            CMD_STX: begin r.store_value = cpu_x; r.store_valid = 1'b1; end
            CMD_STY: begin r.store_value = cpu_y; r.store_valid = 1'b1; end
            CMD_ADC, CMD_SBC:
            begin
                if (c.command == CMD_ADC)
                    sum = {1'b0, cpu_a} + {1'b0, c.operand} + {8'h00, carry_in};
                else
                    sum = {1'b0, cpu_a} + {1'b0, ~c.operand} + {8'h00, carry_in};
                value = sum[7:0];
                cpu_p[FLAG_C] = sum[8];
                if (c.command == CMD_ADC)
                    cpu_p[FLAG_V] = (cpu_a[7] == c.operand[7]) && (value[7] != cpu_a[7]);
                else
                    cpu_p[FLAG_V] = (cpu_a[7] != c.operand[7]) && (value[7] != cpu_a[7]);
                cpu_a = value;
                set_zn(value);
            end
            CMD_CMP: compare_with(cpu_a, c.operand);
            CMD_CPX: compare_with(cpu_x, c.operand);
            CMD_CPY: compare_with(cpu_y, c.operand);
            CMD_AND: begin cpu_a = cpu_a & c.operand; set_zn(cpu_a); end
            CMD_ORA: begin cpu_a = cpu_a | c.operand; set_zn(cpu_a); end
            CMD_EOR: begin cpu_a = cpu_a ^ c.operand; set_zn(cpu_a); end
            CMD_BIT:
            begin
                cpu_p[FLAG_Z] = ((cpu_a & c.operand) == 8'h00);
                cpu_p[FLAG_N] = c.operand[7];
                cpu_p[FLAG_V] = c.operand[6];
            end
            CMD_ASL, CMD_LSR, CMD_ROL, CMD_ROR:
            begin
                shift_src = c.on_accumulator ? cpu_a : c.operand;
                if (c.command == CMD_ASL || c.command == CMD_ROL)
                begin
                    value = {shift_src[6:0], (c.command == CMD_ROL) && carry_in};
                    cpu_p[FLAG_C] = shift_src[7];
                end
                else
                begin
                    value = {(c.command == CMD_ROR) && carry_in, shift_src[7:1]};
                    cpu_p[FLAG_C] = shift_src[0];
                end
                set_zn(value);
                if (c.on_accumulator)
                    cpu_a = value;
                else
                begin
                    r.store_value = value;
                    r.store_valid = 1'b1;
                end
            end
            CMD_INC, CMD_DEC:
            begin
                value = (c.command == CMD_INC) ? c.operand + 8'h01 : c.operand - 8'h01;
                set_zn(value);
                r.store_value = value;
                r.store_valid = 1'b1;
            end
            CMD_CLC: cpu_p[FLAG_C] = 1'b0;
            CMD_SEC: cpu_p[FLAG_C] = 1'b1;
            CMD_CLD: cpu_p[FLAG_D] = 1'b0;
            CMD_SED: cpu_p[FLAG_D] = 1'b1;
            CMD_CLI: cpu_p[FLAG_I] = 1'b0;
            CMD_SEI: cpu_p[FLAG_I] = 1'b1;
            CMD_CLV: cpu_p[FLAG_V] = 1'b0;
            CMD_BPL: r.branch_taken = !cpu_p[FLAG_N];
            CMD_BMI: r.branch_taken = cpu_p[FLAG_N];
            CMD_BVC: r.branch_taken = !cpu_p[FLAG_V];
            CMD_BVS: r.branch_taken = cpu_p[FLAG_V];
            CMD_BCC: r.branch_taken = !cpu_p[FLAG_C];
            CMD_BCS: r.branch_taken = cpu_p[FLAG_C];
            CMD_BNE: r.branch_taken = !cpu_p[FLAG_Z];
            CMD_BEQ: r.branch_taken = cpu_p[FLAG_Z];
            default: ;
        endcase
        r.acc_out = cpu_a;
        r.x_out = cpu_x;
        r.y_out = cpu_y;
        r.status_out = cpu_p;
        return r;
    endfunction

    task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h got %h", $time, field, want, got);
            error_count++;
        end
    endtask

    task automatic offer_item(cmd_t item, logic typed, res_t want);
        cmd_valid <= 1'b1;
        cmd <= item;
        row_typed <= typed;
        row_want <= want;
        do
            @(posedge clk);
        while (cmd_stall);
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
        begin
            predicted = execute_instruction(cmd);
            expected_results.push_back(row_typed ? row_want : predicted);
            items_taken++;
        end
        if (res_valid && !res_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: expected nothing got %h", $time, res);
                error_count++;
            end
            else
            begin
                oldest = expected_results.pop_front();
                check_field("store_value", oldest.store_value, res.store_value);
                check_field("store_valid", 8'(oldest.store_valid), 8'(res.store_valid));
                check_field("branch_taken", 8'(oldest.branch_taken), 8'(res.branch_taken));
                check_field("acc_out", oldest.acc_out, res.acc_out);
                check_field("x_out", oldest.x_out, res.x_out);
                check_field("y_out", oldest.y_out, res.y_out);
                check_field("status_out", oldest.status_out, res.status_out);
            end
        end
    end

    initial
    begin : sender
        cmd_t item;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < N_DIRECTED; i++)
            offer_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                item.command = 6'($urandom_range(CMD_NONE_LOW, CMD_NONE_HIGH));
            else
                item.command = 6'($urandom_range(CMD_LDA, CMD_BEQ));
            case ($urandom_range(0, 7))
                0: item.operand = 8'h00;
                1: item.operand = 8'hFF;
                2: item.operand = 8'h80;
                3: item.operand = 8'h7F;
                default: item.operand = 8'($urandom);
            endcase
            item.on_accumulator = 1'($urandom_range(0, 1));
            if (i >= RANDOM_ITEMS - QUIET_ITEMS)
                quiet_tail = 1'b1;
            offer_item(item, 1'b0, '0);
        end
        cmd_valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    initial
    begin : receiver
        bit pressure_done;
        pressure_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (quiet_tail)
                res_stall <= 1'b0;
            else if (!pressure_done && items_taken >= PRESSURE_AT)
            begin
                pressure_done = 1'b1;
                res_stall <= 1'b1;
                repeat (PRESSURE_CYCLES) @(posedge clk);
                res_stall <= 1'b0;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                res_stall <= 1'b0;
            end
            else
                res_stall <= 1'b0;
        end
    end

    initial
    begin : finisher
        wait (stimulus_done);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// File: cpu_alu_flags_6502_core.f
rtl/caf6502_pkg.sv
rtl/cpu_alu_flags_6502_core.sv
rtl/caf6502_chk.sv
tb/sv/tb.sv
